@@ sv/assert_macros.svh @@
// Assertion macros shared by the comment stripper RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define CS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cs assertion failed");
// expression must never be true outside reset
`define CS_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("cs forbidden condition seen");
`else
`define CS_ASSERT(lbl, clk, rst_n, prop)
`define CS_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ sv/cs_pkg.sv @@
// Package for the comment stripper: register codes, reset values, queue record type.
// No dependencies.
package cs_pkg;

    localparam int OPEN_MAX = 4;    // bytes held by one 32-bit opener word
    localparam int COUNT_W  = 3;    // width of the per-record byte count, 0..OPEN_MAX

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam logic [31:0] BLOCK_OPEN_RESET  = 32'h0000_2A2F;   // "/*"
    localparam logic [31:0] LINE_OPEN_RESET   = 32'h0000_2F2F;   // "//"
    localparam logic [2:0]  OPEN_LENGTH_RESET = 3'd2;

    typedef enum logic [1:0] {
        REG_BLOCK_BYTES,
        REG_BLOCK_LENGTH,
        REG_LINE_BYTES,
        REG_LINE_LENGTH
    } cfg_reg_t;

    // control part of one record between matcher and serializer
    typedef struct packed {
        logic [COUNT_W-1:0] count;  // bytes to emit, 0 means bare end marker
        logic               last;   // record closes the text
    } burst_ctl_t;

endpackage

@@ sv/cs_fifo.sv @@
// Small register-based queue between matcher and serializer.
// No dependencies.
module cs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_wr     = wr && !full;
    assign do_rd     = rd && not_empty;
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ sv/cs_front.sv @@
// Matcher front end: configuration registers, opener/closer matching, held bytes.
// Depends on cs_pkg and assert_macros.svh; feeds records into cs_fifo.
`include "assert_macros.svh"
module cs_front import cs_pkg::*; #(
    parameter int CAP = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    input  logic             push,
    input  logic [7:0]       in_char,
    input  logic             in_last,
    input  logic             q_full,
    output logic             q_wr,
    output logic [8*CAP-1:0] q_data,
    output burst_ctl_t       q_ctl
);

    localparam int IDX_W  = $clog2(CAP);
    localparam int CNT_W  = $clog2(CAP + 1);
    localparam int SEL_W  = CNT_W + 1;
    localparam int HELD_D = CAP - 1;

    logic [31:0]      block_bytes_reg, line_bytes_reg;
    logic [2:0]       block_len_reg, line_len_reg;
    logic             in_block_reg, in_block_next;
    logic             in_line_reg, in_line_next;
    logic [IDX_W-1:0] bmi_reg, bmi_next;
    logic [IDX_W-1:0] lmi_reg, lmi_next;
    logic [IDX_W-1:0] held_cnt_reg, held_cnt_next;
    logic [7:0]       held_reg [HELD_D];
    logic [7:0]       held_next [HELD_D];

    logic             accept;
    logic [CNT_W-1:0] bl, ll, bl_m1, ll_m1;
    logic [IDX_W-1:0] bi0, li0, bi, li, drop, kp;
    logic [7:0]       bbyte, lbyte;
    logic             push_c;
    logic [CNT_W-1:0] hc, dropx, n_after, keep, emit;
    logic [7:0]       pend [CAP];
    logic [SEL_W-1:0] sel;

    assign accept = push && !q_full;

    // lengths above the word size saturate
    assign bl    = (block_len_reg > 3'(CAP)) ? CNT_W'(CAP) : CNT_W'(block_len_reg);
    assign ll    = (line_len_reg > 3'(CAP)) ? CNT_W'(CAP) : CNT_W'(line_len_reg);
    assign bl_m1 = bl - CNT_W'(1);
    assign ll_m1 = ll - CNT_W'(1);

    // clamp stale indices after a length change
    assign bi0 = (bl == '0) ? '0 : ((CNT_W'(bmi_reg) > bl_m1) ? IDX_W'(bl_m1) : bmi_reg);
    assign li0 = (ll == '0) ? '0 : ((CNT_W'(lmi_reg) > ll_m1) ? IDX_W'(ll_m1) : lmi_reg);

    assign bbyte = block_bytes_reg[{bi0, 3'b000} +: 8];
    assign lbyte = line_bytes_reg[{li0, 3'b000} +: 8];
    assign hc    = CNT_W'(held_cnt_reg);

    always_comb
    begin
        in_block_next = in_block_reg;
        in_line_next  = in_line_reg;
        bi            = bi0;
        li            = li0;
        drop          = '0;
        push_c        = 1'b0;
        priority if (in_block_reg)
        begin
            if (bl != '0)
            begin
                if (in_char == bbyte)
                begin
                    if (bi0 == '0)
                    begin
                        in_block_next = 1'b0;
                        li            = '0;
                    end
                    else
                    begin
                        bi = bi0 - 1'b1;
                    end
                end
                else
                begin
                    // failed close restarts at the top index
                    bi = IDX_W'(bl_m1);
                end
            end
        end
        else if (in_line_reg)
        begin
            if (in_char == CHAR_LF || in_char == CHAR_CR)
            begin
                in_line_next = 1'b0;
                bi           = '0;
                li           = '0;
                push_c       = 1'b1;
            end
        end
        else if (bl != '0 && in_char == bbyte)
        begin
            if (CNT_W'(bi0) >= bl_m1)
            begin
                drop          = bi0;
                li            = '0;
                in_block_next = 1'b1;
            end
            else
            begin
                bi = bi0 + 1'b1;
                if (ll != '0 && in_char == lbyte)
                begin
                    if (CNT_W'(li0) >= ll_m1)
                    begin
                        drop         = li0;
                        bi           = '0;
                        li           = '0;
                        in_line_next = 1'b1;
                    end
                    else
                    begin
                        li     = li0 + 1'b1;
                        push_c = 1'b1;
                    end
                end
                else
                begin
                    li     = '0;
                    push_c = 1'b1;
                end
            end
        end
        else if (ll != '0 && in_char == lbyte)
        begin
            bi = '0;
            if (CNT_W'(li0) >= ll_m1)
            begin
                drop         = li0;
                li           = '0;
                in_line_next = 1'b1;
            end
            else
            begin
                li     = li0 + 1'b1;
                push_c = 1'b1;
            end
        end
        else
        begin
            bi     = '0;
            li     = '0;
            push_c = 1'b1;
        end
    end

    // pending bytes: held ones, then the new byte at the held count
    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            if (i < HELD_D && IDX_W'(i) != held_cnt_reg)
            begin
                pend[i] = held_reg[i];
            end
            else
            begin
                pend[i] = in_char;
            end
        end
    end

    assign dropx   = CNT_W'(drop);
    assign n_after = push_c ? hc + 1'b1 : ((dropx < hc) ? hc - dropx : '0);
    assign kp      = (in_block_next || in_line_next || in_last) ? '0 :
                     ((bi > li) ? bi : li);
    assign keep    = (CNT_W'(kp) < n_after) ? CNT_W'(kp) : n_after;
    assign emit    = n_after - keep;

    always_comb
    begin
        sel = '0;
        for (int i = 0; i < HELD_D; i++)
        begin
            sel = SEL_W'(emit) + SEL_W'(i);
            if (sel < SEL_W'(CAP))
            begin
                held_next[i] = pend[sel[IDX_W-1:0]];
            end
            else
            begin
                held_next[i] = held_reg[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            q_data[8*i +: 8] = pend[i];
        end
    end

    assign q_ctl.count = COUNT_W'(emit);
    assign q_ctl.last  = in_last;
    assign q_wr        = accept && (emit != '0 || in_last);

    // end of text returns the matcher to its reset state
    assign bmi_next      = in_last ? '0 : bi;
    assign lmi_next      = in_last ? '0 : li;
    assign held_cnt_next = in_last ? '0 : IDX_W'(keep);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg <= BLOCK_OPEN_RESET;
            block_len_reg   <= OPEN_LENGTH_RESET;
            line_bytes_reg  <= LINE_OPEN_RESET;
            line_len_reg    <= OPEN_LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BLOCK_BYTES:  block_bytes_reg <= cfg_data;
                REG_BLOCK_LENGTH: block_len_reg   <= cfg_data[2:0];
                REG_LINE_BYTES:   line_bytes_reg  <= cfg_data;
                REG_LINE_LENGTH:  line_len_reg    <= cfg_data[2:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_block_reg <= 1'b0;
            in_line_reg  <= 1'b0;
            bmi_reg      <= '0;
            lmi_reg      <= '0;
            held_cnt_reg <= '0;
        end
        else if (accept)
        begin
            in_block_reg <= in_block_next && !in_last;
            in_line_reg  <= in_line_next && !in_last;
            bmi_reg      <= bmi_next;
            lmi_reg      <= lmi_next;
            held_cnt_reg <= held_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < HELD_D; i++)
            begin
                held_reg[i] <= held_next[i];
            end
        end
    end

    `CS_NEVER(a_one_comment_kind, clk, rst_n, in_block_reg && in_line_reg)
    `CS_ASSERT(a_no_held_in_comment, clk, rst_n, (in_block_reg || in_line_reg) |-> held_cnt_reg == '0)
    `CS_ASSERT(a_last_clears, clk, rst_n, (accept && in_last) |=> (!in_block_reg && !in_line_reg && held_cnt_reg == '0))

endmodule

@@ sv/cs_back.sv @@
// Serializer back end: splits queued records into single result transactions.
// Depends on cs_pkg and assert_macros.svh; reads records from cs_fifo.
`include "assert_macros.svh"
module cs_back import cs_pkg::*; #(
    parameter int CAP = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  logic [8*CAP-1:0] q_data,
    input  burst_ctl_t       q_ctl,
    output logic             q_rd,
    input  logic             pop,
    output logic             empty,
    output logic [7:0]       out_char,
    output logic             out_has_char,
    output logic             out_run_last,
    output logic             out_end_of_text
);

    localparam int IDX_W = $clog2(CAP);

    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         char_reg;
    logic               has_reg, run_last_reg, eot_reg;
    logic [COUNT_W-1:0] r_last;
    logic               at_end, load, has_c;

    // a record with no bytes still yields one bare marker
    assign r_last = (q_ctl.count == '0) ? '0 : q_ctl.count - 1'b1;
    assign at_end = (COUNT_W'(idx_reg) == r_last);
    assign has_c  = (q_ctl.count != '0);
    assign load   = q_valid && (!out_valid_reg || pop);
    assign q_rd   = load && at_end;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = at_end ? '0 : idx_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg     <= has_c ? q_data[{idx_reg, 3'b000} +: 8] : 8'h00;
            has_reg      <= has_c;
            run_last_reg <= at_end;
            eot_reg      <= at_end && q_ctl.last;
        end
    end

    assign empty           = !out_valid_reg;
    assign out_char        = char_reg;
    assign out_has_char    = has_reg;
    assign out_run_last    = run_last_reg;
    assign out_end_of_text = eot_reg;

    `CS_ASSERT(a_idx_needs_record, clk, rst_n, (idx_reg != '0) |-> q_valid)
    `CS_ASSERT(a_idx_in_record, clk, rst_n, q_valid |-> (COUNT_W'(idx_reg) <= r_last))
    `CS_NEVER(a_end_closes_run, clk, rst_n, !empty && out_end_of_text && !out_run_last)

endmodule

@@ sv/comment_stripper.sv @@
// Top level of the comment stripper: matcher, record queue and serializer.
// Depends on cs_pkg, cs_front, cs_fifo and cs_back.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  input     | push / full          | in_char, in_last
//  result    | pop / empty          | out_char, out_has_char, out_run_last,
//            |                      | out_end_of_text
//  config    | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One input byte is matched per cycle while full is low; a byte yielding up to
// one result sustains one transaction per cycle on both sides. A byte that
// releases held bytes becomes a record of up to min(4, DELIM_MAX) results, which
// the serializer sends one per cycle while results are popped; the record queue
// (QUEUE_DEPTH entries) absorbs these bursts and full rises only when it fills.
// The edge that accepts a byte writes its record into the queue; the output
// register loads each result from the queue once it is free or being popped.
// Reset is asynchronous and clears control state and the opener registers;
// no clearing pass is needed. cfg_ready is always high.
module comment_stripper import cs_pkg::*; #(
    parameter int DELIM_MAX   = 4,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input byte queue side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_char,
    input  logic        in_last,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_char,
    output logic        out_has_char,
    output logic        out_run_last,
    output logic        out_end_of_text
);

    // opener bytes usable at once: bounded by the 32-bit opener word
    localparam int CAP    = (DELIM_MAX < OPEN_MAX) ? DELIM_MAX : OPEN_MAX;
    localparam int DATA_W = 8 * CAP;
    localparam int REC_W  = $bits(burst_ctl_t) + DATA_W;

    logic              q_wr, q_rd, q_full, q_valid;
    logic [DATA_W-1:0] wr_bytes, rd_bytes;
    burst_ctl_t        wr_ctl, rd_ctl;
    logic [REC_W-1:0]  rd_rec;

    // config is taken every cycle; the user must write only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;
    assign full      = q_full;

    // front: classify each byte, update matcher state, build one record
    cs_front #(
        .CAP (CAP)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .in_char   (in_char),
        .in_last   (in_last),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_data    (wr_bytes),
        .q_ctl     (wr_ctl)
    );

    // record queue decouples matcher from serializer
    cs_fifo #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (q_wr),
        .wr_data   ({wr_ctl, wr_bytes}),
        .rd        (q_rd),
        .rd_data   (rd_rec),
        .full      (q_full),
        .not_empty (q_valid)
    );

    assign rd_ctl   = rd_rec[REC_W-1:DATA_W];
    assign rd_bytes = rd_rec[DATA_W-1:0];

    // back: one result transaction per cycle into the output register while it is free or popped
    cs_back #(
        .CAP (CAP)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_data          (rd_bytes),
        .q_ctl           (rd_ctl),
        .q_rd            (q_rd),
        .pop             (pop),
        .empty           (empty),
        .out_char        (out_char),
        .out_has_char    (out_has_char),
        .out_run_last    (out_run_last),
        .out_end_of_text (out_end_of_text)
    );

endmodule

@@ tb/sv/cs_result_checker.sv @@
// Result checker for the comment stripper: watches the config, input and result channels,
// predicts the cleaned byte stream and compares each popped result with it.
// Depends on cs_pkg.
`timescale 1ns / 100ps

module cs_result_checker import cs_pkg::*; #(
    parameter int DELIM_MAX = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              push,
    input  logic              full,
    input  logic [7:0]        in_char,
    input  logic              in_last,
    input  logic              empty,
    input  logic              pop,
    input  logic [7:0]        out_char,
    input  logic              out_has_char,
    input  logic              out_run_last,
    input  logic              out_end_of_text,
    output int unsigned       pending_count,
    output int unsigned       fail_count
);

    localparam int unsigned LEN_CAP   = (DELIM_MAX < OPEN_MAX) ? DELIM_MAX : OPEN_MAX;
    localparam int unsigned SHOW_MAX  = 30;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_ch;
        logic       run_last;
        logic       text_end;
    } clean_rec_t;

    clean_rec_t  clean_q[$];        // cleaned text still owed by the block
    clean_rec_t  head;

    // opener registers as the block should hold them
    logic [31:0] blk_word;
    logic [31:0] line_word;
    logic [2:0]  blk_len;
    logic [2:0]  line_len;

    // matcher state
    bit          in_blk;
    bit          in_line;
    int unsigned blk_idx;
    int unsigned line_idx;
    int unsigned held_n;
    logic [7:0]  held [DELIM_MAX];

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        fail_count++;
        if (fail_count <= SHOW_MAX)
            $display("%0t: mismatch on %s, got %h expected %h", $realtime, what, got, want);
    endtask

    function automatic logic [7:0] open_byte(input logic [31:0] w, input int unsigned k);
        return (k < 4) ? w[8*k +: 8] : 8'h00;
    endfunction

    task automatic clear_text_state();
        int i;
        in_blk   = 1'b0;
        in_line  = 1'b0;
        blk_idx  = 0;
        line_idx = 0;
        held_n   = 0;
        for (i = 0; i < DELIM_MAX; i++)
            held[i] = 8'h00;
    endtask

    // One text byte in, zero or more cleaned-text records out.
    task automatic predict_strip(input logic [7:0] c, input logic fin);
        int unsigned bl, ll, n, keep, emit, i;
        logic [7:0]  pend [DELIM_MAX+1];
        clean_rec_t  run [$];
        clean_rec_t  rec;

        bl = (blk_len > LEN_CAP) ? LEN_CAP : blk_len;
        ll = (line_len > LEN_CAP) ? LEN_CAP : line_len;
        n  = (held_n < DELIM_MAX) ? held_n : DELIM_MAX - 1;
        for (i = 0; i < DELIM_MAX; i++)
            pend[i] = held[i];
        pend[DELIM_MAX] = 8'h00;

        // a shorter opener pulls a partial match back to its last byte
        if (bl == 0)
            blk_idx = 0;
        else if (blk_idx > bl - 1)
            blk_idx = bl - 1;
        if (ll == 0)
            line_idx = 0;
        else if (line_idx > ll - 1)
            line_idx = ll - 1;

        if (in_blk)
        begin
            // close = opener backward; a miss restarts at the top index
            if (bl != 0)
            begin
                if (c == open_byte(blk_word, blk_idx))
                begin
                    if (blk_idx == 0)
                    begin
                        in_blk   = 1'b0;
                        line_idx = 0;
                    end
                    else
                        blk_idx--;
                end
                else
                    blk_idx = bl - 1;
            end
        end
        else if (in_line)
        begin
            if (c == CHAR_LF || c == CHAR_CR)
            begin
                in_line  = 1'b0;
                blk_idx  = 0;
                line_idx = 0;
                pend[n]  = c;
                n++;
            end
        end
        else if (bl != 0 && c == open_byte(blk_word, blk_idx))
        begin
            if (blk_idx >= bl - 1)
            begin
                n       -= (blk_idx < n) ? blk_idx : n;
                line_idx = 0;
                in_blk   = 1'b1;
            end
            else
            begin
                blk_idx++;
                if (ll != 0 && c == open_byte(line_word, line_idx))
                begin
                    if (line_idx >= ll - 1)
                    begin
                        n       -= (line_idx < n) ? line_idx : n;
                        blk_idx  = 0;
                        line_idx = 0;
                        in_line  = 1'b1;
                    end
                    else
                        line_idx++;
                end
                else
                    line_idx = 0;
                if (!in_line)
                begin
                    pend[n] = c;
                    n++;
                end
            end
        end
        else if (ll != 0 && c == open_byte(line_word, line_idx))
        begin
            blk_idx = 0;
            if (line_idx >= ll - 1)
            begin
                n       -= (line_idx < n) ? line_idx : n;
                line_idx = 0;
                in_line  = 1'b1;
            end
            else
            begin
                line_idx++;
                pend[n] = c;
                n++;
            end
        end
        else
        begin
            blk_idx  = 0;
            line_idx = 0;
            pend[n]  = c;
            n++;
        end

        // hold back as many bytes as the longer partial match covers
        if (in_blk || in_line || fin)
            keep = 0;
        else
            keep = (blk_idx > line_idx) ? blk_idx : line_idx;
        if (keep > n)
            keep = n;
        emit = n - keep;

        for (i = 0; i < emit; i++)
        begin
            rec = '{ch: pend[i], has_ch: 1'b1, run_last: 1'b0, text_end: 1'b0};
            run.insert(run.size(), rec);
        end
        for (i = 0; i < keep; i++)
            held[i] = pend[emit + i];
        held_n = keep;

        if (fin)
        begin
            if (run.size() == 0)
            begin
                rec = '{ch: 8'h00, has_ch: 1'b0, run_last: 1'b0, text_end: 1'b0};
                run.insert(run.size(), rec);
            end
            run[run.size() - 1].text_end = 1'b1;
            clear_text_state();
        end
        if (run.size() > 0)
            run[run.size() - 1].run_last = 1'b1;
        foreach (run[j])
            clean_q.insert(clean_q.size(), run[j]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_word  = BLOCK_OPEN_RESET;
            line_word = LINE_OPEN_RESET;
            blk_len   = OPEN_LENGTH_RESET;
            line_len  = OPEN_LENGTH_RESET;
            clear_text_state();
            clean_q.delete();
            pending_count <= 0;
        end
        else
        begin
            // result transaction: oldest owed record, field by field
            if (pop && !empty)
            begin
                if (clean_q.size() == 0)
                    report_mismatch("result with nothing owed (out_char)", out_char, 8'h00);
                else
                begin
                    head = clean_q.pop_front();
                    if (out_char !== head.ch)
                        report_mismatch("out_char", out_char, head.ch);
                    if (out_has_char !== head.has_ch)
                        report_mismatch("out_has_char", 8'(out_has_char), 8'(head.has_ch));
                    if (out_run_last !== head.run_last)
                        report_mismatch("out_run_last", 8'(out_run_last), 8'(head.run_last));
                    if (out_end_of_text !== head.text_end)
                        report_mismatch("out_end_of_text", 8'(out_end_of_text),
                                        8'(head.text_end));
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_BLOCK_BYTES:  blk_word  = cfg_data;
                    REG_BLOCK_LENGTH: blk_len   = cfg_data[2:0];
                    REG_LINE_BYTES:   line_word = cfg_data;
                    REG_LINE_LENGTH:  line_len  = cfg_data[2:0];
                    default: ;
                endcase
            end

            if (push && !full)
                predict_strip(in_char, in_last);

            pending_count <= clean_q.size();
        end
    end

endmodule

@@ tb/sv/comment_stripper_tb.sv @@
// Top of the comment stripper testbench: clock, reset, opener setup, text stimulus and
// result-side flow control; the verdict comes from the failure count of cs_result_checker.
// Depends on cs_pkg, comment_stripper and cs_result_checker.
`timescale 1ns / 100ps

module comment_stripper_tb;
    import cs_pkg::*;

    localparam int DELIM_MAX     = 4;
    localparam int QUEUE_DEPTH   = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int TOTAL_ITEMS   = 450;     // random phases stop here
    localparam int SETTLE_CYCLES = 6;       // margin after the last result before config writes
    localparam int DRAIN_CYCLES  = 20;
    localparam int LONG_HOLD     = 400;     // receiver hold-off that fills the block
    localparam int TIMEOUT_NS    = 3_000_000;

    // opener bytes used to build texts whose openers share bytes
    localparam logic [31:0] OVERLAP_BYTES = {8'h23, CHAR_LF, 8'h2A, 8'h2F};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;
    logic        push      = 1'b0;
    logic        full;
    logic [7:0]  in_char   = '0;
    logic        in_last   = 1'b0;
    logic        empty;
    logic        pop       = 1'b0;
    logic [7:0]  out_char;
    logic        out_has_char;
    logic        out_run_last;
    logic        out_end_of_text;

    int unsigned pending_count;
    int unsigned fail_count;

    // stimulus-side copy of the openers, used only to shape the texts
    logic [31:0] blk_bytes  = BLOCK_OPEN_RESET;
    logic [31:0] line_bytes = LINE_OPEN_RESET;
    logic [2:0]  blk_len    = OPEN_LENGTH_RESET;
    logic [2:0]  line_len   = OPEN_LENGTH_RESET;

    logic [7:0]  text_q[$];
    int unsigned bytes_sent    = 0;
    bit          tx_steady     = 1'b0;   // sender offers back to back
    bit          long_hold_req = 1'b0;   // asks the receiver for one long hold-off

    always #2 clk = ~clk;

    comment_stripper #(
        .DELIM_MAX   (DELIM_MAX),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .in_char         (in_char),
        .in_last         (in_last),
        .empty           (empty),
        .pop             (pop),
        .out_char        (out_char),
        .out_has_char    (out_has_char),
        .out_run_last    (out_run_last),
        .out_end_of_text (out_end_of_text)
    );

    cs_result_checker #(
        .DELIM_MAX (DELIM_MAX)
    ) result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .in_char         (in_char),
        .in_last         (in_last),
        .empty           (empty),
        .pop             (pop),
        .out_char        (out_char),
        .out_has_char    (out_has_char),
        .out_run_last    (out_run_last),
        .out_end_of_text (out_end_of_text),
        .pending_count   (pending_count),
        .fail_count      (fail_count)
    );

    // Idle gap before an input transaction: mostly none, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (tx_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Text byte biased toward opener bytes and newlines so matches happen often.
    function automatic logic [7:0] pick_byte();
        int unsigned r, k;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 3);
        if (r < 35)
            return 8'($urandom_range(0, 255));
        if (r < 60)
            return blk_bytes[8*k +: 8];
        if (r < 80)
            return line_bytes[8*k +: 8];
        if (r < 90)
            return ($urandom_range(0, 1) != 0) ? CHAR_LF : CHAR_CR;
        return 8'h61;
    endfunction

    function automatic logic [31:0] overlap_word();
        logic [31:0] w;
        int unsigned k, j;
        for (k = 0; k < 4; k++)
        begin
            j = $urandom_range(0, 3);
            w[8*k +: 8] = OVERLAP_BYTES[8*j +: 8];
        end
        return w;
    endfunction

    // Length registers only use bits 2:0; the rest is filled now and then.
    function automatic logic [31:0] len_word(input logic [2:0] len);
        return {(($urandom_range(0, 3) == 0) ? 29'($urandom()) : 29'd0), len};
    endfunction

    // One input transaction. push stays high when the next byte follows at once,
    // so it is only lowered where a gap is inserted.
    task automatic send_byte(input logic [7:0] c, input logic fin);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        in_char <= c;
        in_last <= fin;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_str(input string s, input bit fin);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], fin && (i == s.len() - 1));
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Writes all four opener registers once the block owes nothing. A byte can
    // leave no result, so a settling margin passes before the first write.
    task automatic set_openers(input logic [31:0] bb, input logic [2:0] bl,
                               input logic [31:0] lb, input logic [2:0] ll);
        push <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_BLOCK_BYTES, bb);
        write_reg(REG_BLOCK_LENGTH, len_word(bl));
        write_reg(REG_LINE_BYTES, lb);
        write_reg(REG_LINE_LENGTH, len_word(ll));
        cfg_valid  <= 1'b0;
        blk_bytes  = bb;
        blk_len    = bl;
        line_bytes = lb;
        line_len   = ll;
    endtask

    // Builds a text from well-formed pieces (whole comments, partial openers,
    // plain runs) and sends it; fin marks the final byte as end of text.
    task automatic send_text(input int unsigned len, input bit fin);
        int unsigned bl, ll, k, n, cut;
        logic [31:0] w;
        bl = (blk_len > 4) ? 4 : blk_len;
        ll = (line_len > 4) ? 4 : line_len;
        text_q.delete();
        while (text_q.size() < len)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n) text_q.insert(text_q.size(), pick_byte());
                end
                1:
                begin
                    // block comment: opener, body, opener backward
                    if (bl != 0)
                    begin
                        for (k = 0; k < bl; k++)
                            text_q.insert(text_q.size(), blk_bytes[8*k +: 8]);
                        n = $urandom_range(0, 6);
                        repeat (n) text_q.insert(text_q.size(), pick_byte());
                        for (k = bl; k > 0; k--)
                            text_q.insert(text_q.size(), blk_bytes[8*(k-1) +: 8]);
                    end
                end
                2:
                begin
                    // line comment closed by CR or LF
                    if (ll != 0)
                    begin
                        for (k = 0; k < ll; k++)
                            text_q.insert(text_q.size(), line_bytes[8*k +: 8]);
                        n = $urandom_range(0, 6);
                        repeat (n) text_q.insert(text_q.size(), 8'($urandom_range(32, 126)));
                        text_q.insert(text_q.size(),
                                      ($urandom_range(0, 1) != 0) ? CHAR_LF : CHAR_CR);
                    end
                end
                3:
                begin
                    // opener cut short, then any byte
                    if ($urandom_range(0, 1) != 0)
                    begin
                        w = blk_bytes;
                        n = bl;
                    end
                    else
                    begin
                        w = line_bytes;
                        n = ll;
                    end
                    if (n >= 2)
                    begin
                        cut = $urandom_range(1, n - 1);
                        for (k = 0; k < cut; k++)
                            text_q.insert(text_q.size(), w[8*k +: 8]);
                    end
                    text_q.insert(text_q.size(), pick_byte());
                end
                4:
                    text_q.insert(text_q.size(),
                                  ($urandom_range(0, 1) != 0) ? CHAR_LF : CHAR_CR);
                default:
                begin
                    n = $urandom_range(1, 4);
                    repeat (n) text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
                end
            endcase
        end
        for (k = 0; k < text_q.size(); k++)
            send_byte(text_q[k], fin && (k == text_q.size() - 1));
    endtask

    // Result side: pop with random holds, steady stretches, and one long
    // hold-off on request, counted here in cycles.
    initial
    begin : result_sink
        int unsigned quiet, steady, r;
        quiet  = 0;
        steady = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (quiet > 0)
            begin
                pop <= 1'b0;
                quiet--;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                quiet = LONG_HOLD - 1;
                pop <= 1'b0;
            end
            else if (steady > 0)
            begin
                pop <= 1'b1;
                steady--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                begin
                    quiet = $urandom_range(15, 60);
                    pop <= 1'b0;
                end
                else if (r < 18)
                begin
                    quiet = $urandom_range(0, 2);
                    pop <= 1'b0;
                end
                else
                begin
                    pop <= 1'b1;
                    if (r > 95)
                        steady = $urandom_range(30, 80);
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned phase, texts, t;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed part, default "/*" and "//" openers ----
        set_openers(BLOCK_OPEN_RESET, OPEN_LENGTH_RESET, LINE_OPEN_RESET, OPEN_LENGTH_RESET);
        send_str("/*x*/b//\n", 1'b0);   // block comment, line comment, newline kept
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_str("/", 1'b1);            // held opener byte released by end of text

        // four-byte openers: three held bytes plus the current byte in one burst
        set_openers({"D", "C", "B", "A"}, 3'd4, {"Z", "Y", "X", "W"}, 3'd4);
        send_str("ABC", 1'b0);
        send_str("x", 1'b1);

        // shorter opener mid-text: the partial match is clamped, held bytes released,
        // then the final byte lands inside the comment and gives a bare end marker
        send_str("ABC", 1'b0);
        set_openers({"D", "C", "B", "A"}, 3'd2, {"Z", "Y", "X", "W"}, 3'd4);
        send_str("Bz", 1'b1);

        // block opener disabled while inside a block comment: bytes keep dropping
        set_openers(BLOCK_OPEN_RESET, 3'd2, LINE_OPEN_RESET, 3'd2);
        send_str("/*a", 1'b0);
        set_openers(BLOCK_OPEN_RESET, 3'd0, LINE_OPEN_RESET, 3'd2);
        send_str("*", 1'b0);
        set_openers(BLOCK_OPEN_RESET, 3'd2, LINE_OPEN_RESET, 3'd2);
        send_str("*/z", 1'b1);

        // ---- random part: one opener setting per phase ----
        phase = 0;
        while (bytes_sent < TOTAL_ITEMS)
        begin
            case (phase % 9)
                0: set_openers(BLOCK_OPEN_RESET, OPEN_LENGTH_RESET,
                               LINE_OPEN_RESET, OPEN_LENGTH_RESET);
                1: set_openers(overlap_word(), 3'd4, overlap_word(), 3'($urandom_range(2, 4)));
                2: set_openers(overlap_word(), 3'd1, overlap_word(), 3'd1);
                3: set_openers(BLOCK_OPEN_RESET, 3'd0, overlap_word(), 3'd3);
                4: set_openers(overlap_word(), 3'd4, LINE_OPEN_RESET, 3'd0);
                5: set_openers(overlap_word(), 3'($urandom_range(5, 7)),
                               overlap_word(), 3'($urandom_range(4, 7)));
                6: set_openers(32'hFFFF_FFFF, 3'd4, 32'h0000_0000, 3'd7);
                7: set_openers($urandom(), 3'($urandom_range(0, 7)),
                               $urandom(), 3'($urandom_range(0, 7)));
                default: set_openers($urandom(), 3'd0, $urandom(), 3'd0);
            endcase

            tx_steady = ($urandom_range(0, 3) == 0);
            if (phase == 2)
            begin
                // receiver stops for a long stretch while bytes keep coming,
                // so the record queue fills and full pushes back
                long_hold_req = 1'b1;
                tx_steady     = 1'b1;
                send_text(60, 1'b1);
                tx_steady     = 1'b0;
            end
            if (phase == 4)
            begin
                // sender waits until every owed result has been taken
                push <= 1'b0;
                @(posedge clk);
                while (pending_count != 0)
                    @(posedge clk);
            end

            // an unfinished last text carries its state into the next setting
            texts = $urandom_range(1, 3);
            for (t = 0; t < texts; t++)
                send_text($urandom_range(6, 28), (t + 1 < texts) || ($urandom_range(0, 3) != 0));
            phase++;
        end

        // ---- drain and verdict ----
        push <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
